@@ rtl/core/sccn_pkg.sv @@
package sccn_pkg;

  typedef logic signed [15:0] sample_t;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int WEIGHT_W = 9;
  localparam int BAND_W = 15;
  localparam int CFG_IDX_W = 3;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALERT_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALERT_BAND  = 3'd4;

  // Control for the window cells: load a new sample or take one ranking step.
  typedef struct packed {
    logic shift;
    logic rotate;
  } cell_ctl_t;

  // Control for the averaging stage.
  typedef struct packed {
    logic ema;
    logic alert;
  } smooth_ctl_t;

endpackage

@@ rtl/core/sccn_if.sv @@
interface sccn_in_if;
  import sccn_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface sccn_out_if;
  import sccn_pkg::*;
  logic    valid;
  logic    ready;
  sample_t clamped;
  sample_t median_value;
  sample_t smoothed;
  logic    alert;

  modport source (output valid, output clamped, output median_value, output smoothed,
                  output alert, input ready);
  modport sink (input valid, input clamped, input median_value, input smoothed,
                input alert, output ready);
endinterface

@@ rtl/core/sccn_cell.sv @@
module sccn_cell #(
  parameter int IDX_W = 3
) (
  input  logic                clk,
  input  sccn_pkg::cell_ctl_t ctl,
  input  logic [IDX_W-1:0]    cell_index,
  input  sccn_pkg::sample_t   value_in,
  input  logic                load_valid,
  input  sccn_pkg::sample_t   probe_in,
  input  logic [IDX_W-1:0]    probe_age_in,
  input  logic                probe_valid_in,
  output sccn_pkg::sample_t   value,
  output sccn_pkg::sample_t   probe,
  output logic [IDX_W-1:0]    probe_age,
  output logic                probe_valid,
  output logic [IDX_W-1:0]    rank
);
  import sccn_pkg::*;

  sample_t          value_r, probe_r;
  logic [IDX_W-1:0] age_r, rank_r;
  logic             pvalid_r;
  logic             below;

  // A probe ranks below this cell if it is smaller, or equal and newer in the line.
  assign below = pvalid_r && ((probe_r < value_r) || ((probe_r == value_r) && (age_r < cell_index)));

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      value_r  <= value_in;
      probe_r  <= value_in;
      age_r    <= cell_index;
      pvalid_r <= load_valid;
      rank_r   <= '0;
    end else if (ctl.rotate) begin
      probe_r  <= probe_in;
      age_r    <= probe_age_in;
      pvalid_r <= probe_valid_in;
      rank_r   <= rank_r + IDX_W'(below);
    end
  end

  assign value       = value_r;
  assign probe       = probe_r;
  assign probe_age   = age_r;
  assign probe_valid = pvalid_r;
  assign rank        = rank_r;

endmodule

@@ rtl/core/sccn_window.sv @@
module sccn_window #(
  parameter int WINDOW = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sccn_pkg::cell_ctl_t ctl,
  input  sccn_pkg::sample_t   sample_in,
  output logic                rank_last,
  output sccn_pkg::sample_t   median
);
  import sccn_pkg::*;

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);

  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  logic [IDX_W-1:0] mid_idx;

  sample_t          value_w  [WINDOW];
  sample_t          probe_w  [WINDOW];
  logic [IDX_W-1:0] age_w    [WINDOW];
  logic             pvalid_w [WINDOW];
  logic [IDX_W-1:0] rank_w   [WINDOW];

  always_comb begin
    fill_nxt = fill_r;
    if (ctl.shift && (fill_r < CNT_W'(WINDOW))) begin
      fill_nxt = fill_r + CNT_W'(1);
    end
  end

  always_comb begin
    step_nxt = step_r;
    if (ctl.shift) begin
      step_nxt = '0;
    end else if (ctl.rotate) begin
      step_nxt = rank_last ? '0 : step_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      step_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      step_r <= step_nxt;
    end
  end

  assign rank_last = ctl.rotate && (step_r == IDX_W'(WINDOW - 1));

  // Newest sample enters cell 0; probes travel the ring in the other direction.
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    sccn_cell #(.IDX_W(IDX_W)) u_cell (
      .clk           (clk),
      .ctl           (ctl),
      .cell_index    (IDX_W'(i)),
      .value_in      ((i == 0) ? sample_in : value_w[(i + WINDOW - 1) % WINDOW]),
      .load_valid    (CNT_W'(i) < fill_nxt),
      .probe_in      (probe_w[(i + 1) % WINDOW]),
      .probe_age_in  (age_w[(i + 1) % WINDOW]),
      .probe_valid_in(pvalid_w[(i + 1) % WINDOW]),
      .value         (value_w[i]),
      .probe         (probe_w[i]),
      .probe_age     (age_w[i]),
      .probe_valid   (pvalid_w[i]),
      .rank          (rank_w[i])
    );
  end

  assign mid_idx = IDX_W'(fill_r >> 1);

  // Ranks are unique, so exactly one filled cell holds the middle rank.
  always_comb begin
    median = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if ((CNT_W'(i) < fill_r) && (rank_w[i] == mid_idx)) begin
        median = median | value_w[i];
      end
    end
  end

endmodule

@@ rtl/core/sccn_smooth.sv @@
module sccn_smooth (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sccn_pkg::smooth_ctl_t        ctl,
  input  sccn_pkg::sample_t            med,
  input  logic [sccn_pkg::WEIGHT_W-1:0] weight,
  input  sccn_pkg::sample_t            level,
  input  logic [sccn_pkg::BAND_W-1:0]  band,
  output sccn_pkg::sample_t            avg,
  output logic                         alert_nxt
);
  import sccn_pkg::*;

  sample_t              avg_r, avg_nxt;
  logic                 seeded_r;
  logic                 alert_r;
  logic [WEIGHT_W-1:0]  w_eff;
  logic signed [16:0]   diff;
  logic signed [26:0]   prod;
  logic signed [26:0]   sum;
  logic signed [17:0]   avg_x, hi, lo;

  assign w_eff = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;

  // w*med + (256-w)*avg written as w*(med-avg) + 256*avg; the shift floors.
  assign diff = 17'(med) - 17'(avg_r);
  assign prod = $signed({1'b0, w_eff}) * diff;
  assign sum  = prod + (27'(avg_r) <<< 8);
  assign avg_nxt = sum[23:8];

  assign avg_x = 18'(avg_r);
  assign hi = 18'(level) + $signed({3'b000, band});
  assign lo = 18'(level) - $signed({3'b000, band});
  assign alert_nxt = alert_r ? (avg_x >= lo) : (avg_x > hi);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r    <= '0;
      seeded_r <= 1'b0;
      alert_r  <= 1'b0;
    end else begin
      if (ctl.ema) begin
        avg_r    <= seeded_r ? avg_nxt : med;
        seeded_r <= 1'b1;
      end
      if (ctl.alert) begin
        alert_r <= alert_nxt;
      end
    end
  end

  assign avg = avg_r;

endmodule

@@ rtl/core/sensor_conditioning_chain.sv @@
// Sensor conditioning chain: clamp, running median, exponential average and
// hysteresis alert on a stream of signed 16-bit samples.
//
// in_ch carries one sample per request; out_ch returns one result per sample
// (clamped value, window median, smoothed value, alert flag). Both use
// valid/ready; a request moves at a clock edge with valid and ready high.
// The cfg_ port is APB-style, five 32-bit registers at byte offsets 0..16.
// They must be written by the user only while the block is idle (not enforced).
//
// The median is found by a ring of WINDOW cells that pass ranking probes to
// their neighbors, one step per cycle. An accepted sample passes through the
// ranking, median, averaging and output states in that order, and the next
// sample is accepted only after it has returned to idle, so in_ch.ready is
// high only between samples.
//
// A finished result sits in an output register, and the next sample may be
// accepted while it waits. If the receiver stalls, a second result holds in
// the last stage until the register frees. Reset clears the window fill,
// the average, the alert and the output valid, and restores register defaults.
module sensor_conditioning_chain #(
  parameter int WINDOW = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  sccn_in_if.sink                           in_ch,
  sccn_out_if.source                        out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [sccn_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [sccn_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [sccn_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import sccn_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RANK = 3'd1;
  localparam logic [2:0] ST_MED  = 3'd2;
  localparam logic [2:0] ST_EMA  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  sample_t             clamp_low_r, clamp_high_r, level_r;
  logic [WEIGHT_W-1:0] weight_r;
  logic [BAND_W-1:0]   band_r;
  sample_t             clamped, clamped_r, med_r, median;
  sample_t             avg;
  logic                alert_nxt;
  logic                accept, rank_last, out_load, cfg_wr;
  logic [CFG_IDX_W-1:0] cfg_idx;
  cell_ctl_t           cell_ctl;
  smooth_ctl_t         smooth_ctl;

  logic    out_valid_r, out_alert_r;
  sample_t out_clamped_r, out_med_r, out_avg_r;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_low_r  <= 16'sh8000;
      clamp_high_r <= 16'sh7fff;
      weight_r     <= 9'd64;
      level_r      <= '0;
      band_r       <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CLAMP_LOW:   clamp_low_r  <= cfg_pwdata[15:0];
        REG_CLAMP_HIGH:  clamp_high_r <= cfg_pwdata[15:0];
        REG_WEIGHT:      weight_r     <= cfg_pwdata[WEIGHT_W-1:0];
        REG_ALERT_LEVEL: level_r      <= cfg_pwdata[15:0];
        REG_ALERT_BAND:  band_r       <= cfg_pwdata[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CLAMP_LOW:   cfg_prdata = CFG_DATA_W'(clamp_low_r);
      REG_CLAMP_HIGH:  cfg_prdata = CFG_DATA_W'(clamp_high_r);
      REG_WEIGHT:      cfg_prdata = CFG_DATA_W'(weight_r);
      REG_ALERT_LEVEL: cfg_prdata = CFG_DATA_W'(level_r);
      REG_ALERT_BAND:  cfg_prdata = CFG_DATA_W'(band_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // Crossed limits resolve toward the lower one first.
  always_comb begin
    if (in_ch.sample < clamp_low_r) begin
      clamped = clamp_low_r;
    end else if (in_ch.sample > clamp_high_r) begin
      clamped = clamp_high_r;
    end else begin
      clamped = in_ch.sample;
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  assign cell_ctl.shift    = accept;
  assign cell_ctl.rotate   = (state_r == ST_RANK);
  assign smooth_ctl.ema    = (state_r == ST_EMA);
  assign smooth_ctl.alert  = out_load;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept)    state_nxt = ST_RANK;
      ST_RANK: if (rank_last) state_nxt = ST_MED;
      ST_MED:                 state_nxt = ST_EMA;
      ST_EMA:                 state_nxt = ST_OUT;
      ST_OUT:  if (out_load)  state_nxt = ST_IDLE;
      default:                state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      clamped_r <= clamped;
    end
    if (state_r == ST_MED) begin
      med_r <= median;
    end
    if (out_load) begin
      out_clamped_r <= clamped_r;
      out_med_r     <= med_r;
      out_avg_r     <= avg;
      out_alert_r   <= alert_nxt;
    end
  end

  sccn_window #(.WINDOW(WINDOW)) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (cell_ctl),
    .sample_in(clamped),
    .rank_last(rank_last),
    .median   (median)
  );

  sccn_smooth u_smooth (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (smooth_ctl),
    .med      (med_r),
    .weight   (weight_r),
    .level    (level_r),
    .band     (band_r),
    .avg      (avg),
    .alert_nxt(alert_nxt)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.clamped      = out_clamped_r;
  assign out_ch.median_value = out_med_r;
  assign out_ch.smoothed     = out_avg_r;
  assign out_ch.alert        = out_alert_r;

`ifndef ASSERT_OFF
  a_accept_starts_rank: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_RANK))
    else $error("accepted sample did not start ranking");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_OUT) && out_valid_r && !out_ch.ready) |=> (state_r == ST_OUT))
    else $error("finished result left the last stage while the output was full");

  a_valid_from_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_OUT))
    else $error("output became valid without a finished result");
`endif

endmodule
